FILE: hdl/lossc_pkg.sv
// ----------------------------------------------------------------------------
// lossc_pkg
// Shared sizes, register indexes and the line-buffer control bundle of the
// largest owned square scan.
// ----------------------------------------------------------------------------
package lossc_pkg;

  // grid limits
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  // position counters
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  // internal square value and count widths
  localparam int VAL_W = $clog2(MAX_COLS + 1);
  localparam int CNT_W = $clog2(MAX_COLS * MAX_ROWS + 1);

  // register and field widths
  localparam int DIM_W   = 7;
  localparam int OWNER_W = 4;
  localparam int LS_W    = 7;
  localparam int OC_W    = 13;

  // port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - LS_W - OC_W;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 7;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_TARGET_OWNER = 2'd2
  } cfg_idx_t;

  // control bundle broadcast along the line buffer
  typedef struct packed {
    logic             adv;
    logic             wrap;
    logic [VAL_W-1:0] wr_val;
  } line_ctl_t;

endpackage

FILE: hdl/largest_owned_square_scan_core.sv
// ----------------------------------------------------------------------------
// largest_owned_square_scan_core
// Maximal-square scan over a raster stream of owner codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one grid cell per request, row-major order, owner
//   code in in_tdata[3:0]. The grid size comes from grid_width and
//   grid_height, the counted owner from target_owner, all set through the
//   cfg_* write port (index 0 width, 1 height, 2 target owner).
//   Result channel out_*: one request per frame, after the last cell of the
//   frame: largest square side and number of owned cells.
// Throughput: one cell per cycle while in_tready is high. Each cell needs a line-buffer read from
//   the token-holding column cell, a three-way minimum and a compare, all
//   done in the cycle the cell is accepted.
// Latency: the result is registered and shows on out_tvalid in the cycle
//   after the last cell of the frame is accepted.
// Reset: synchronous; configuration returns to 64 x 64 with owner 1, the
//   position, running results and line buffer are cleared, no result pends.
// Stall: the result register holds while out_tready is low; cells are still
//   taken then, except while a held result is stalled (in_tready low).
// ----------------------------------------------------------------------------
module largest_owned_square_scan_core import lossc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [3:0] owner_code, rest zero
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [6:0] largest_square,
                                             // [19:7] owned_cells, rest zero
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int WC_W = COL_W + 1;
  localparam int HR_W = ROW_W + 1;

  // configuration registers
  logic [DIM_W-1:0]   grid_width_r, grid_height_r;
  logic [OWNER_W-1:0] target_owner_r;

  // scan state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [VAL_W-1:0] left_r, left_nxt, diag_r, diag_nxt, best_r, best_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic [LS_W-1:0] out_ls_r, out_ls_nxt;
  logic [OC_W-1:0] out_oc_r, out_oc_nxt;

  logic             accept, hit, last_col, last_row;
  logic [WC_W-1:0]  w_eff;
  logic [HR_W-1:0]  h_eff;
  logic [VAL_W-1:0] up_val, min_ul, min3, v;
  line_ctl_t        line_ctl;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= DIM_W'(64);
      grid_height_r  <= DIM_W'(64);
      target_owner_r <= OWNER_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_GRID_WIDTH:   grid_width_r   <= cfg_wdata[DIM_W-1:0];
        CFG_GRID_HEIGHT:  grid_height_r  <= cfg_wdata[DIM_W-1:0];
        CFG_TARGET_OWNER: target_owner_r <= cfg_wdata[OWNER_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero acts as one, oversize clamps to the limit
  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = WC_W'(1);
    end else if (32'(grid_width_r) > MAX_COLS) begin
      w_eff = WC_W'(MAX_COLS);
    end else begin
      w_eff = WC_W'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      h_eff = HR_W'(1);
    end else if (32'(grid_height_r) > MAX_ROWS) begin
      h_eff = HR_W'(MAX_ROWS);
    end else begin
      h_eff = HR_W'(grid_height_r);
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign hit       = (in_tdata[OWNER_W-1:0] == target_owner_r);
  assign last_col  = (WC_W'(col_r) + WC_W'(1)) >= w_eff;
  assign last_row  = (HR_W'(row_r) + HR_W'(1)) >= h_eff;

  // square value of the current cell
  always_comb begin
    min_ul = (up_val < left_r) ? up_val : left_r;
    min3   = (min_ul < diag_r) ? min_ul : diag_r;
    if (!hit) begin
      v = '0;
    end else if (col_r != '0 && row_r != '0) begin
      v = min3 + VAL_W'(1);
    end else begin
      v = VAL_W'(1);
    end
  end

  // line buffer
  always_comb begin
    line_ctl.adv    = accept;
    line_ctl.wrap   = last_col;
    line_ctl.wr_val = v;
  end

  lossc_line u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (line_ctl),
    .up_val(up_val)
  );

  // position, neighbors and running results
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    best_nxt      = best_r;
    cnt_nxt       = cnt_r;
    out_ls_nxt    = out_ls_r;
    out_oc_nxt    = out_oc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (accept) begin
      best_nxt = (v > best_r) ? v : best_r;
      cnt_nxt  = hit ? cnt_r + CNT_W'(1) : cnt_r;
      if (!last_col) begin
        col_nxt  = col_r + COL_W'(1);
        left_nxt = v;
        diag_nxt = up_val;
      end else begin
        col_nxt  = '0;
        left_nxt = '0;
        diag_nxt = '0;
        if (!last_row) begin
          row_nxt = row_r + ROW_W'(1);
        end else begin
          // frame end: publish and restart
          out_ls_nxt    = LS_W'(best_nxt);
          out_oc_nxt    = OC_W'(cnt_nxt);
          out_valid_nxt = 1'b1;
          row_nxt       = '0;
          best_nxt      = '0;
          cnt_nxt       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      diag_r      <= '0;
      best_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      diag_r      <= diag_nxt;
      best_r      <= best_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_ls_r <= out_ls_nxt;
    out_oc_r <= out_oc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_oc_r, out_ls_r};

endmodule

FILE: hdl/lossc_cell.sv
// ----------------------------------------------------------------------------
// lossc_cell
// One column of the line buffer: holds the square value of its column from
// the row above and passes the column token on to its neighbor.
// ----------------------------------------------------------------------------
module lossc_cell import lossc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  line_ctl_t        ctl,
  input  logic             head,       // high for the first column only
  input  logic             token_in,   // token from the left neighbor
  output logic             token_out,
  output logic [VAL_W-1:0] rd_val      // own value when holding the token
);

  logic             token_r, token_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;

  // token moves one column per request, back to the head at row end
  always_comb begin
    token_nxt = token_r;
    value_nxt = value_r;
    if (ctl.adv) begin
      token_nxt = ctl.wrap ? head : token_in;
      if (token_r) begin
        value_nxt = ctl.wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= head;
      value_r <= '0;
    end else begin
      token_r <= token_nxt;
      value_r <= value_nxt;
    end
  end

  assign token_out = token_r;
  assign rd_val    = token_r ? value_r : '0;

endmodule

FILE: hdl/lossc_line.sv
// ----------------------------------------------------------------------------
// lossc_line
// Row of column cells forming the line buffer; the cell that holds the
// token supplies the value from the row above.
// ----------------------------------------------------------------------------
module lossc_line import lossc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  line_ctl_t        ctl,
  output logic [VAL_W-1:0] up_val
);

  logic [MAX_COLS-1:0]           token;
  logic [MAX_COLS-1:0][VAL_W-1:0] rd_val;

  // chain of cells, token handed left to right
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    lossc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .head     (i == 0),
      .token_in ((i == 0) ? 1'b0 : token[(i == 0) ? 0 : i - 1]),
      .token_out(token[i]),
      .rd_val   (rd_val[i])
    );
  end

  // only one cell drives a nonzero value
  always_comb begin
    up_val = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      up_val = up_val | rd_val[i];
    end
  end

endmodule

FILE: hdl/lossc_checker.sv
// ----------------------------------------------------------------------------
// lossc_checker
// Port-level checks on the largest owned square scan, bound to the top level.
// ----------------------------------------------------------------------------
module lossc_checker import lossc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no cell is taken while a finished result is stalled
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted over a stalled result");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // a square exists exactly when some cell is owned
  a_square_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[LS_W-1:0] == '0) == (out_tdata[LS_W+OC_W-1:LS_W] == '0)))
    else $error("largest square and owned count disagree");

endmodule

bind largest_owned_square_scan_core lossc_checker u_lossc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
